// File: hw/rtl/ilst_pkg.sv
// Shared types, codes and widths for the indexed list store.
package ilst_pkg;

    // Field widths of one command beat and one result beat
    localparam int OP_W  = 3;
    localparam int POS_W = 8;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int CNT_W = 9;

    // Default number of list entries
    localparam int DEF_CAPACITY = 256;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 3'd0,
        OP_FRONT  = 3'd1,
        OP_BACK   = 3'd2,
        OP_AT     = 3'd3,
        OP_DELETE = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_GATHER,
        S_REPLY
    } t_state;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

// File: hw/rtl/ilst_cell.sv
// One list cell: holds a single entry and shifts with its neighbors.
module ilst_cell #(
    parameter int IDX = 0,
    parameter int IW  = 8
) (
    input  logic                      i_clk,
    input  ilst_pkg::t_cell_ctl       i_ctl,
    input  logic [IW-1:0]             i_pos,
    input  logic [ilst_pkg::VAL_W-1:0] i_val,
    input  logic [ilst_pkg::VAL_W-1:0] i_prev,
    input  logic [ilst_pkg::VAL_W-1:0] i_next,
    output logic [ilst_pkg::VAL_W-1:0] o_val
);
    import ilst_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] n_val;

    // Pick the new entry: take the left neighbor above an insert point, the new
    // value at it, the right neighbor at or above a delete point, else hold
    always_comb begin
        n_val = r_val;
        if (i_ctl.ins) begin
            if (MY_IDX > i_pos) begin
                n_val = i_prev;
            end else if (MY_IDX == i_pos) begin
                n_val = i_val;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX >= i_pos) begin
                n_val = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

// File: hw/rtl/ilst_read_sel.sv
// Two-level registered select that reads one cell of the chain.
module ilst_read_sel #(
    parameter int CAP = 256,
    parameter int IW  = 8
) (
    input  logic                       i_clk,
    input  logic [ilst_pkg::VAL_W-1:0] i_cells [CAP],
    input  logic [IW-1:0]              i_idx,
    input  logic                       i_load_grp,
    input  logic                       i_load_out,
    output logic [ilst_pkg::VAL_W-1:0] o_val
);
    import ilst_pkg::*;

    // Cells per group, groups, and padded sizes
    localparam int LW   = (IW < 4) ? IW : 4;
    localparam int GRP  = 1 << LW;
    localparam int NG   = (CAP + GRP - 1) / GRP;
    localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
    localparam int NGP  = 1 << GW;
    localparam int PADN = NGP * GRP;

    logic [VAL_W-1:0] w_pad [PADN];
    logic [VAL_W-1:0] r_grp [NGP];
    logic [VAL_W-1:0] r_out;
    logic [LW-1:0]    w_lo;
    logic [GW-1:0]    w_hi;

    assign w_lo = i_idx[LW-1:0];
    assign w_hi = GW'(i_idx >> LW);

    // Pad the cell row with zeros up to whole groups
    genvar gp;
    generate
        for (gp = 0; gp < PADN; gp++) begin : g_pad
            if (gp < CAP) begin : g_cell
                assign w_pad[gp] = i_cells[gp];
            end else begin : g_zero
                assign w_pad[gp] = '0;
            end
        end
    endgenerate

    // First level: one entry out of each group
    always_ff @(posedge i_clk) begin
        if (i_load_grp) begin
            for (int g = 0; g < NGP; g++) begin
                r_grp[g] <= w_pad[g * GRP + int'(w_lo)];
            end
        end
    end

    // Second level: one group out of all
    always_ff @(posedge i_clk) begin
        if (i_load_out) begin
            r_out <= r_grp[w_hi];
        end
    end

    assign o_val = r_out;

endmodule

// File: hw/rtl/indexed_list_store_unit.sv
// Top level of the indexed list store: command control, cell chain and read select.
// An ordered list of up to CAPACITY signed 32-bit entries, one entry per cell
// of a chain; insert and delete shift every cell from the point on together,
// in the execute step. A command beat is taken when start is high and busy is
// low. Every command passes through accept, execute and reply; an in-range
// read adds a gather step between execute and reply, for the second level of
// the registered read select across the cell row. busy stays high until the
// result beat has been shown, so a new command can be taken in the cycle after
// the strobe. The result sits on the o_ ports for exactly one cycle with
// o_strobe high; the receiver cannot hold it off and must take it then. count
// reports the low 9 bits of the entry count after the command.
module indexed_list_store_unit #(
    parameter int CAPACITY = ilst_pkg::DEF_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ilst_pkg::OP_W-1:0]         i_operation,
    input  logic [ilst_pkg::POS_W-1:0]        i_position,
    input  logic signed [ilst_pkg::VAL_W-1:0] i_value,
    output logic                              o_strobe,
    output logic signed [ilst_pkg::VAL_W-1:0] o_read_value,
    output logic [ilst_pkg::ST_W-1:0]         o_status,
    output logic [ilst_pkg::CNT_W-1:0]        o_count
);
    import ilst_pkg::*;

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CMPW-1:0] CAP_V = CMPW'(CAPACITY);

    // Control and payload registers
    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [OP_W-1:0]   r_op;
    logic [POS_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_val;
    t_status           r_status;
    t_status           n_status;
    logic              r_rd_ok;
    logic              n_rd_ok;

    // Execute-stage decode
    logic [CMPW-1:0]   w_pos_c;
    logic [CMPW-1:0]   w_cnt_c;
    logic              w_full;
    logic [IW-1:0]     w_ins_pos;
    logic [IW-1:0]     w_pos_idx;
    t_cell_ctl         w_ctl;
    logic              w_accept;

    logic [VAL_W-1:0]  w_cell [CAPACITY];
    logic [VAL_W-1:0]  w_rd_val;

    assign w_accept  = start && !busy;
    assign w_pos_c   = CMPW'(r_pos);
    assign w_cnt_c   = CMPW'(r_count);
    assign w_full    = (w_cnt_c >= CAP_V);
    assign w_pos_idx = IW'(w_pos_c);

    // Hold the command beat while it is worked on
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_operation;
            r_pos <= i_position;
            r_val <= i_value;
        end
    end

    // State, count and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
    end

    // Decode the command and sequence its cycles
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_status  = STAT_DONE;
        n_rd_ok   = 1'b0;
        w_ctl     = '0;
        w_ins_pos = w_pos_idx;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_REPLY;
                case (t_op'(r_op))
                    OP_READ: begin
                        if (w_pos_c < w_cnt_c) begin
                            n_rd_ok = 1'b1;
                            n_state = S_GATHER;
                        end else begin
                            n_status = STAT_RANGE;
                        end
                    end
                    OP_FRONT, OP_BACK: begin
                        if (w_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            w_ctl.ins = 1'b1;
                            w_ins_pos = (t_op'(r_op) == OP_FRONT) ? '0 : IW'(r_count);
                            n_count   = r_count + CW'(1);
                        end
                    end
                    OP_AT: begin
                        if (w_pos_c > w_cnt_c) begin
                            n_status = STAT_RANGE;
                        end else if (w_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            w_ctl.ins = 1'b1;
                            n_count   = r_count + CW'(1);
                        end
                    end
                    OP_DELETE: begin
                        if (w_pos_c < w_cnt_c) begin
                            w_ctl.del = 1'b1;
                            n_count   = r_count - CW'(1);
                        end else begin
                            n_status = STAT_RANGE;
                        end
                    end
                    default: begin
                        n_status = STAT_RANGE;
                    end
                endcase
            end
            S_GATHER: begin
                n_state = S_REPLY;
            end
            S_REPLY: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Chain of cells, one entry each
    genvar gc;
    generate
        for (gc = 0; gc < CAPACITY; gc++) begin : g_cell
            logic [VAL_W-1:0] w_prev;
            logic [VAL_W-1:0] w_next;
            if (gc == 0) begin : g_first
                assign w_prev = r_val;
            end else begin : g_mid_l
                assign w_prev = w_cell[gc-1];
            end
            if (gc == CAPACITY - 1) begin : g_last
                assign w_next = w_cell[gc];
            end else begin : g_mid_r
                assign w_next = w_cell[gc+1];
            end
            ilst_cell #(
                .IDX (gc),
                .IW  (IW)
            ) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_pos  (w_ins_pos),
                .i_val  (r_val),
                .i_prev (w_prev),
                .i_next (w_next),
                .o_val  (w_cell[gc])
            );
        end
    endgenerate

    // Registered read across the cell row
    ilst_read_sel #(
        .CAP (CAPACITY),
        .IW  (IW)
    ) u_read_sel (
        .i_clk      (i_clk),
        .i_cells    (w_cell),
        .i_idx      (w_pos_idx),
        .i_load_grp (r_state == S_EXEC),
        .i_load_out (r_state == S_GATHER),
        .o_val      (w_rd_val)
    );

    // Drive the result beat
    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = (r_state == S_REPLY);
    assign o_read_value = r_rd_ok ? w_rd_val : '1;
    assign o_status     = r_status;
    assign o_count      = CNT_W'(r_count);

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CMPW'(r_count) <= CAP_V))
        else $error("entry count above capacity");

    a_count_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |-> ($past(r_state) == S_EXEC))
        else $error("entry count changed outside execute cycle");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == STAT_FULL)) |-> (CMPW'(r_count) == CAP_V))
        else $error("full status reported on a list that is not full");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_strobe))
        else $error("accepted command did not raise busy");

endmodule
